[design/hrpt_pkg.sv]
// Shared types and codes for the hash range partition table.
// Depends on nothing; imported by hrpt_cell, the top level and both testbench files.
package hrpt_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_RECORD = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_DUP_ID    = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	localparam logic [31:0] HASH_TOP = 32'hFFFF_FFFF;
	localparam logic [31:0] KEYS_MAX = 32'hFFFF_FFFF;

	// One table entry: half-open range [range_lo, range_hi), owner and key count.
	typedef struct packed {
		logic [31:0] range_lo;
		logic [31:0] range_hi;
		logic [15:0] ident;
		logic [31:0] keys;
	} entry_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic        first;
		logic        split;
		logic        bump;
		logic [31:0] probe;
		logic [15:0] ident;
		logic [31:0] mid;
		logic [31:0] high;
	} cell_ctl_t;

endpackage

[design/hrpt_cell.sv]
// One table cell: holds an entry, matches it against the probe hash and id,
// passes the running key maximum and shifted entries to the next cell. Uses hrpt_pkg.
module hrpt_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrpt_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]    pick,
	input  logic [CNT_W-1:0]    count,
	input  hrpt_pkg::entry_t    left_entry,
	input  logic [31:0]         left_best_keys,
	input  logic [IDX_W-1:0]    left_best_idx,
	output hrpt_pkg::entry_t    entry,
	output logic [31:0]         best_keys,
	output logic [IDX_W-1:0]    best_idx,
	output logic                hit,
	output logic                dup
);
	import hrpt_pkg::*;

	entry_t            ent_q;
	logic [31:0]       best_keys_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              active;
	logic [IDX_W:0]    pos;
	logic [IDX_W:0]    me;

	assign active = CNT_W'(INDEX) < count;
	assign hit    = active && (ent_q.range_lo <= ctl.probe) && (ctl.probe < ent_q.range_hi);
	assign dup    = active && (ent_q.ident == ctl.ident);
	assign pos    = {1'b0, pick} + (IDX_W+1)'(1);
	assign me     = (IDX_W+1)'(INDEX);

	// Running maximum; strict compare keeps the earliest entry on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_keys_q <= '0;
			best_idx_q  <= '0;
		end else if (active && (ent_q.keys > left_best_keys)) begin
			best_keys_q <= ent_q.keys;
			best_idx_q  <= IDX_W'(INDEX);
		end else begin
			best_keys_q <= left_best_keys;
			best_idx_q  <= left_best_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.first && (INDEX == 0)) begin
			ent_q <= '{range_lo: 32'd0, range_hi: HASH_TOP, ident: ctl.ident, keys: 32'd0};
		end else if (ctl.split) begin
			if (me == {1'b0, pick}) begin
				ent_q.range_hi <= ctl.mid;
			end else if (me == pos) begin
				ent_q <= '{range_lo: ctl.mid, range_hi: ctl.high, ident: ctl.ident, keys: 32'd0};
			end else if (me > pos) begin
				ent_q <= left_entry;
			end
		end else if (ctl.bump && hit && (ent_q.keys != KEYS_MAX)) begin
			ent_q.keys <= ent_q.keys + 32'd1;
		end
	end

	assign entry     = ent_q;
	assign best_keys = best_keys_q;
	assign best_idx  = best_idx_q;

endmodule

[design/hash_range_partition_table_unit.sv]
// Hash range partition table: a row of MAX_NODES cells, one entry each.
// Lookup, record, refused adds and the first add: capture, then cell match. Other
// accepted adds: capture, then scan while the key-maximum chain moves one cell
// per cycle through every cell, then split. One item in flight; the next
// transfer is taken once the result register is free. Reset empties the table at once.
module hash_range_partition_table_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [15:0] node_id,
	input  logic [31:0] key_hash,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [15:0] owner_id,
	output logic [31:0] key_count,
	output logic [31:0] range_low,
	output logic [31:0] range_high
);
	import hrpt_pkg::*;

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SPLIT
	} state_t;

	state_t            state_q;
	logic [1:0]        cmd_q;
	logic [15:0]       id_q;
	logic [31:0]       hash_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_q;

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [15:0]       owner_q;
	logic [31:0]       keys_q;
	logic [31:0]       low_q;
	logic [31:0]       high_q;

	cell_ctl_t         ctl;
	entry_t            ent      [MAX_NODES];
	logic [31:0]       bkeys    [MAX_NODES];
	logic [IDX_W-1:0]  bidx     [MAX_NODES];
	logic [MAX_NODES-1:0] hits;
	logic [MAX_NODES-1:0] dups;

	logic              req_xfer;
	logic              is_add;
	logic              is_record;
	logic              any_hit;
	logic              any_dup;
	logic              full;
	logic              empty;
	entry_t            hit_ent;
	entry_t            pick_ent;
	logic [IDX_W-1:0]  pick;
	logic [31:0]       mid;
	logic [32:0]       span_sum;
	logic [31:0]       hit_keys;

	// Hold new transfers while an item is at work or the result waits.
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_xfer  = req_valid && !req_stall;

	assign is_add    = (cmd_q == CMD_ADD);
	assign is_record = (cmd_q == CMD_RECORD);
	assign any_hit   = |hits;
	assign any_dup   = |dups;
	assign full      = count_q >= CNT_W'(MAX_NODES);
	assign empty     = count_q == '0;

	// Ranges stay disjoint, so at most one cell hits: merge by OR.
	always_comb begin
		hit_ent = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (hits[i]) hit_ent = hit_ent | ent[i];
		end
	end

	assign hit_keys = (is_record && (hit_ent.keys != KEYS_MAX)) ? hit_ent.keys + 32'd1
	                                                             : hit_ent.keys;

	// The last cell carries the winner of the key-maximum chain.
	assign pick     = bidx[MAX_NODES-1];
	assign pick_ent = ent[pick];
	assign span_sum = {1'b0, pick_ent.range_lo} + {1'b0, pick_ent.range_hi};
	assign mid      = span_sum[32:1];

	always_comb begin
		ctl       = '0;
		ctl.probe = hash_q;
		ctl.ident = id_q;
		ctl.mid   = mid;
		ctl.high  = pick_ent.range_hi;
		if (state_q == ST_EXEC) begin
			ctl.first = is_add && !any_dup && !full && empty;
			ctl.bump  = is_record;
		end
		if (state_q == ST_SPLIT) begin
			ctl.split = 1'b1;
		end
	end

	for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
		entry_t           l_ent;
		logic [31:0]      l_keys;
		logic [IDX_W-1:0] l_idx;

		if (g == 0) begin : g_head
			// Chain head: no entry to shift in, maximum starts at zero on entry zero.
			assign l_ent  = '0;
			assign l_keys = 32'd0;
			assign l_idx  = '0;
		end else begin : g_link
			assign l_ent  = ent[g-1];
			assign l_keys = bkeys[g-1];
			assign l_idx  = bidx[g-1];
		end

		hrpt_cell #(
			.INDEX (g),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.pick           (pick),
			.count          (count_q),
			.left_entry     (l_ent),
			.left_best_keys (l_keys),
			.left_best_idx  (l_idx),
			.entry          (ent[g]),
			.best_keys      (bkeys[g]),
			.best_idx       (bidx[g]),
			.hit            (hits[g]),
			.dup            (dups[g])
		);
	end

	// Capture the request; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q  <= command;
			id_q   <= node_id;
			hash_q <= key_hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			owner_q     <= '0;
			keys_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (is_add) begin
						if (any_dup || full) begin
							rsp_valid_q <= 1'b1;
							status_q    <= any_dup ? STAT_DUP_ID : STAT_FULL;
							owner_q     <= '0;
							keys_q      <= '0;
							low_q       <= '0;
							high_q      <= '0;
							state_q     <= ST_IDLE;
						end else if (empty) begin
							rsp_valid_q <= 1'b1;
							status_q    <= STAT_OK;
							owner_q     <= id_q;
							keys_q      <= '0;
							low_q       <= '0;
							high_q      <= HASH_TOP;
							count_q     <= CNT_W'(1);
							state_q     <= ST_IDLE;
						end else begin
							// Let the maximum ripple through every cell.
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end else begin
						rsp_valid_q <= 1'b1;
						status_q    <= any_hit ? STAT_OK : STAT_NOT_FOUND;
						owner_q     <= hit_ent.ident;
						keys_q      <= any_hit ? hit_keys : 32'd0;
						low_q       <= hit_ent.range_lo;
						high_q      <= hit_ent.range_hi;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(MAX_NODES - 1)) state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					// Picked entry keeps the lower half, the new node takes the upper.
					rsp_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					owner_q     <= id_q;
					keys_q      <= '0;
					low_q       <= mid;
					high_q      <= pick_ent.range_hi;
					count_q     <= count_q + CNT_W'(1);
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign owner_id   = owner_q;
	assign key_count  = keys_q;
	assign range_low  = low_q;
	assign range_high = high_q;

endmodule

[tb/partition_table_checker.sv]
// Checker for the hash range partition table: watches both channels, keeps its own
// copy of the node table and compares every result transfer. Depends on hrpt_pkg.
module partition_table_checker #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  command,
	input  logic [15:0] node_id,
	input  logic [31:0] key_hash,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  status,
	input  logic [15:0] owner_id,
	input  logic [31:0] key_count,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output int          mismatch_count,
	output int          replies_waiting
);
	import hrpt_pkg::*;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] owner;
		logic [31:0] keys;
		logic [31:0] lo;
		logic [31:0] hi;
	} table_reply_t;

	logic [31:0] lo_tab [SLOTS];
	logic [31:0] hi_tab [SLOTS];
	logic [15:0] id_tab [SLOTS];
	logic [31:0] keys_tab [SLOTS];
	int          nodes_used;

	table_reply_t replies_due [$];

	function automatic table_reply_t slot_reply(input int s, input status_t st);
		table_reply_t r;
		r.st = st;
		if (s < 0) begin
			r.owner = '0;
			r.keys  = '0;
			r.lo    = '0;
			r.hi    = '0;
		end else begin
			r.owner = id_tab[s];
			r.keys  = keys_tab[s];
			r.lo    = lo_tab[s];
			r.hi    = hi_tab[s];
		end
		return r;
	endfunction

	// Apply one command to the table copy and return the reply it should give.
	function automatic table_reply_t table_apply(input logic [1:0] c, input logic [15:0] id,
			input logic [31:0] h);
		bit          dup;
		int          pick, pos, hit;
		logic [31:0] best, split_hi;
		logic [32:0] span_sum;
		dup  = 1'b0;
		pick = 0;
		hit  = -1;
		best = '0;
		if (c == CMD_ADD) begin
			for (int i = 0; i < nodes_used; i++) begin
				if (id_tab[i] == id)
					dup = 1'b1;
				if (keys_tab[i] > best) begin
					best = keys_tab[i];
					pick = i;
				end
			end
			if (dup)
				return slot_reply(-1, STAT_DUP_ID);
			if (nodes_used >= SLOTS)
				return slot_reply(-1, STAT_FULL);
			if (nodes_used == 0) begin
				lo_tab[0]   = '0;
				hi_tab[0]   = HASH_TOP;
				id_tab[0]   = id;
				keys_tab[0] = '0;
				nodes_used  = 1;
				return slot_reply(0, STAT_OK);
			end
			// split the busiest entry: it keeps the lower half, the new node the upper
			span_sum = {1'b0, lo_tab[pick]} + {1'b0, hi_tab[pick]};
			split_hi = hi_tab[pick];
			pos = pick + 1;
			for (int i = nodes_used; i > pos; i--) begin
				lo_tab[i]   = lo_tab[i - 1];
				hi_tab[i]   = hi_tab[i - 1];
				id_tab[i]   = id_tab[i - 1];
				keys_tab[i] = keys_tab[i - 1];
			end
			hi_tab[pick]  = span_sum[32:1];
			lo_tab[pos]   = span_sum[32:1];
			hi_tab[pos]   = split_hi;
			id_tab[pos]   = id;
			keys_tab[pos] = '0;
			nodes_used++;
			return slot_reply(pos, STAT_OK);
		end
		for (int i = 0; i < nodes_used; i++) begin
			if (hit < 0 && lo_tab[i] <= h && h < hi_tab[i])
				hit = i;
		end
		if (hit < 0)
			return slot_reply(-1, STAT_NOT_FOUND);
		if (c == CMD_RECORD && keys_tab[hit] != KEYS_MAX)
			keys_tab[hit]++;
		return slot_reply(hit, STAT_OK);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		mismatch_count  = 0;
		replies_waiting = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		table_reply_t due;
		if (!arst_n) begin
			nodes_used = 0;
			replies_due.delete();
			replies_waiting = 0;
		end else begin
			// results first: a reply always belongs to an earlier request
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatch_count++;
				end else begin
					due = replies_due.pop_front();
					check_field("status", 32'(due.st), 32'(status));
					check_field("owner_id", 32'(due.owner), 32'(owner_id));
					check_field("key_count", due.keys, key_count);
					check_field("range_low", due.lo, range_low);
					check_field("range_high", due.hi, range_high);
				end
			end
			if (req_valid && !req_stall)
				replies_due.push_back(table_apply(command, node_id, key_hash));
			replies_waiting = replies_due.size();
		end
	end

endmodule

[tb/hash_range_partition_table_unit_test.sv]
// Top of the partition table testbench: clock, reset, request stimulus and result
// back-pressure. Depends on hrpt_pkg, the block and partition_table_checker.
module hash_range_partition_table_unit_test;
	import hrpt_pkg::*;

	localparam int TABLE_SLOTS = 16;
	// command value 3 has no name in the package; the block treats it as a plain lookup
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1130;
	// an accepted add walks the key-maximum chain one cell per cycle
	localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  command;
	logic [15:0] node_id;
	logic [31:0] key_hash;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic [15:0] owner_id;
	logic [31:0] key_count;
	logic [31:0] range_low;
	logic [31:0] range_high;

	int          mismatch_count;
	int          replies_waiting;
	int unsigned items_sent;
	bit          tx_quiet;
	bit          hold_off;

	hash_range_partition_table_unit #(
		.MAX_NODES(TABLE_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.node_id   (node_id),
		.key_hash  (key_hash),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.owner_id  (owner_id),
		.key_count (key_count),
		.range_low (range_low),
		.range_high(range_high)
	);

	partition_table_checker #(
		.SLOTS(TABLE_SLOTS)
	) table_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.command        (command),
		.node_id        (node_id),
		.key_hash       (key_hash),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.owner_id       (owner_id),
		.key_count      (key_count),
		.range_low      (range_low),
		.range_high     (range_high),
		.mismatch_count (mismatch_count),
		.replies_waiting(replies_waiting)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop: far beyond the slowest legal run of all items.
	initial begin : run_limit
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one request transfer. Idle for a drawn number of cycles first (none
	// while the sender runs quiet), then hold the payload until the block takes it.
	task automatic offer(input logic [1:0] c, input logic [15:0] id, input logic [31:0] h);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		command   <= c;
		node_id   <= id;
		key_hash  <= h;
		// sample the stall at the rising edge; the transfer happens when it is low
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// Result side: after each transfer, stall for a drawn number of cycles. Every
	// 50 results decide whether to run quiet for a while. Stall also while a long
	// hold-off is in force.
	initial begin : result_sink
		int unsigned wait_left;
		int unsigned taken;
		bit          rx_quiet;
		rsp_stall = 1'b0;
		wait_left = 0;
		taken     = 0;
		rx_quiet  = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				taken++;
				if (taken % 50 == 0)
					rx_quiet = ($urandom_range(0, 3) == 0);
				wait_left = rx_quiet ? 0 : $urandom_range(0, 5);
			end
			@(negedge clk);
			rsp_stall <= hold_off || (wait_left != 0);
			if (wait_left != 0)
				wait_left--;
		end
	end

	// Long hold-offs: block the result side for many cycles while the sender keeps
	// offering, so the single in-flight slot fills and the block stalls its input.
	initial begin : long_hold
		hold_off = 1'b0;
		for (int k = 0; k < 2; k++) begin
			wait (items_sent >= (k == 0 ? 40 : 600));
			@(posedge clk);
			hold_off = 1'b1;
			repeat (k == 0 ? 80 : 150) @(posedge clk);
			hold_off = 1'b0;
		end
	end

	initial begin : stimulus
		int unsigned roll;
		int unsigned shift_by;
		logic [1:0]  c;
		logic [15:0] id;
		logic [31:0] h;
		req_valid  = 1'b0;
		command    = CMD_LOOKUP;
		node_id    = '0;
		key_hash   = '0;
		arst_n     = 1'b0;
		tx_quiet   = 1'b0;
		items_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Empty table: every lookup and record misses.
		offer(CMD_LOOKUP, 16'h0000, 32'h0000_0000);
		offer(CMD_RECORD, 16'h0000, 32'h1234_5678);
		// First node owns everything but the top hash; a second add of it is a duplicate.
		offer(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
		offer(CMD_ADD, 16'hFFFF, 32'h0000_0000);
		offer(CMD_LOOKUP, 16'h0000, 32'h0000_0000);
		offer(CMD_LOOKUP, 16'h0000, HASH_TOP - 1);
		offer(CMD_LOOKUP, 16'h0000, HASH_TOP);
		offer(CMD_RECORD, 16'h0000, 32'h7FFF_FFFF);
		offer(CMD_RECORD, 16'h0000, 32'h0000_0001);
		offer(CMD_RECORD, 16'hFFFF, HASH_TOP);
		offer(CMD_SPARE, 16'h0000, 32'h8000_0000);
		// Split at the midpoint, then probe both sides of the new boundary.
		offer(CMD_ADD, 16'h0000, 32'h0000_0000);
		offer(CMD_LOOKUP, 16'h0000, 32'h7FFF_FFFE);
		offer(CMD_LOOKUP, 16'h0000, 32'h7FFF_FFFF);
		offer(CMD_RECORD, 16'h0000, HASH_TOP - 1);
		offer(CMD_RECORD, 16'h0000, HASH_TOP - 1);
		// Both entries now hold two keys: the tie sends the next adds to the lowest
		// start; then a duplicate add.
		offer(CMD_ADD, 16'h5555, 32'h0000_0000);
		offer(CMD_ADD, 16'hAAAA, 32'h0000_0000);
		offer(CMD_SPARE, 16'hFFFF, 32'hBFFF_FFFF);
		offer(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFE);
		offer(CMD_ADD, 16'h5555, 32'hFFFF_FFFF);

		// Random part. Adds are rare so the table fills gradually and later adds
		// hit the full and duplicate cases; ids come half from a small pool.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				c = CMD_ADD;
			else if (roll < 5)
				c = CMD_SPARE;
			else if (roll < 50)
				c = CMD_LOOKUP;
			else
				c = CMD_RECORD;
			id = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 23));
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				h = $urandom;
			end else if (roll < 7) begin
				// range edges sit at coarse multiples, one below: straddle them
				shift_by = $urandom_range(20, 31);
				h = ($urandom & (32'hFFFF_FFFF << shift_by)) + 32'($urandom_range(0, 3))
					- 32'd2;
			end else if (roll < 8) begin
				case ($urandom_range(0, 3))
					0: h = '0;
					1: h = 32'd1;
					2: h = HASH_TOP - 1;
					default: h = HASH_TOP;
				endcase
			end else begin
				// hot region: keep one area busy so splits go deep there
				h = $urandom_range(0, 32'h0FFF_FFFF);
			end
			offer(c, id, h);
		end

		// Drop valid, drain the outstanding results, then allow the block to settle.
		@(negedge clk);
		req_valid <= 1'b0;
		wait (replies_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && replies_waiting == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
